>>> src/frpf_pkg.sv
// shared constants and types for the flat region peak finder
// no dependencies; imported by frpf_eval, flat_region_peak_finder and the bench

package frpf_pkg;

    // default widths of the amplitude and the index/count fields
    localparam int AMP_WIDTH_DEF   = 24;
    localparam int INDEX_WIDTH_DEF = 16;

    // fixed field widths
    localparam int POS_WIDTH  = 32;
    localparam int THR_WIDTH  = 23;
    localparam int HW_WIDTH   = 31;
    localparam int ADDR_WIDTH = 8;
    localparam int DATA_WIDTH = 32;

    // configuration register indexes
    localparam logic [ADDR_WIDTH-1:0] REG_PEAK_THRESHOLD = 8'd0;
    localparam logic [ADDR_WIDTH-1:0] REG_HALF_WIDTH     = 8'd1;

    // register reset values
    localparam logic [THR_WIDTH-1:0] THR_RESET = 23'd5243;
    localparam logic [HW_WIDTH-1:0]  HW_RESET  = 31'd1073741824;

    // decisions of the compare unit for the held sample
    typedef struct packed {
        logic flat;      // |new amp - held amp| < threshold
        logic in_roi;    // |held pos| < half width
        logic distinct;  // |held amp - last peak amp| > threshold
    } t_eval_flags;

endpackage

>>> src/flat_region_peak_finder.sv
// top level of the flat region peak finder: stream ports, trace state, result register
// depends on frpf_pkg and frpf_eval
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  s        | in        | i_s_tvalid/o_s_tready | tdata: x_pos, y_amp; tuser: trace_start
//  m        | out       | o_m_tvalid/i_m_tready | tdata: peak_index, peak_value, peak_number
//  cfg      | in        | i_cfg_valid/o_cfg_ready | addr: register index; data: value
//
//  one sample is taken every cycle while the input is not stalled; the held-sample
//  compares and the state update finish in the cycle the sample is accepted, and a
//  report appears in the result register on the next cycle.
//  the input is stalled only while a report sits in the result register and the
//  sink holds off. cfg writes are always accepted.
//  synchronous active-low reset restores register defaults and clears trace history.

module flat_region_peak_finder
    import frpf_pkg::*;
#(
    parameter int AMP_WIDTH   = AMP_WIDTH_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
    localparam int IN_W  = ((POS_WIDTH + AMP_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * INDEX_WIDTH + AMP_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_W-1:0]       i_s_tdata,   // x_pos, y_amp, zero pad
    input  logic [0:0]            i_s_tuser,   // trace_start
    // peak stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_W-1:0]      o_m_tdata,   // peak_index, peak_value, peak_number, zero pad
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [DATA_WIDTH-1:0] i_cfg_data
);

    localparam int PAY_W = 2 * INDEX_WIDTH + AMP_WIDTH;

    // configuration registers
    logic [THR_WIDTH-1:0] r_threshold;
    logic [HW_WIDTH-1:0]  r_half_width;

    // trace state
    logic signed [AMP_WIDTH-1:0] r_held_amp;
    logic signed [POS_WIDTH-1:0] r_held_pos;
    logic                        r_held_valid;
    logic [INDEX_WIDTH-1:0]      r_sample_count;
    logic signed [AMP_WIDTH-1:0] r_last_peak_amp;
    logic                        r_peak_seen;
    logic [INDEX_WIDTH-1:0]      r_peaks_reported;

    // result register
    logic                        r_out_valid;
    logic [INDEX_WIDTH-1:0]      r_out_index;
    logic signed [AMP_WIDTH-1:0] r_out_value;
    logic [INDEX_WIDTH-1:0]      r_out_number;

    logic signed [POS_WIDTH-1:0] in_pos;
    logic signed [AMP_WIDTH-1:0] in_amp;
    logic                        in_accept;
    logic                        is_start;
    logic                        fire;
    logic [INDEX_WIDTH-1:0]      n_peaks_reported;
    logic [INDEX_WIDTH-1:0]      n_sample_count;
    t_eval_flags                 flags;

    // unpack the request
    assign in_pos = i_s_tdata[POS_WIDTH-1:0];
    assign in_amp = i_s_tdata[POS_WIDTH +: AMP_WIDTH];

    // handshakes
    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // a new trace begins on the marker or when nothing is held yet
    assign is_start = i_s_tuser[0] || !r_held_valid;

    frpf_eval #(
        .AMP_WIDTH (AMP_WIDTH)
    ) u_eval (
        .i_new_amp    (in_amp),
        .i_held_amp   (r_held_amp),
        .i_held_pos   (r_held_pos),
        .i_last_amp   (r_last_peak_amp),
        .i_threshold  (r_threshold),
        .i_half_width (r_half_width),
        .o_flags      (flags)
    );

    // report decision for the held sample
    assign fire = in_accept && !is_start && flags.flat && flags.in_roi &&
                  (!r_peak_seen || flags.distinct);

    // saturating counters
    assign n_peaks_reported = (r_peaks_reported == '1) ? r_peaks_reported
                                                       : r_peaks_reported + 1'b1;
    assign n_sample_count   = (r_sample_count == '1) ? r_sample_count
                                                     : r_sample_count + 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= THR_RESET;
            r_half_width <= HW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_PEAK_THRESHOLD: r_threshold  <= i_cfg_data[THR_WIDTH-1:0];
                REG_HALF_WIDTH:     r_half_width <= i_cfg_data[HW_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // trace control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid     <= 1'b0;
            r_sample_count   <= '0;
            r_peak_seen      <= 1'b0;
            r_peaks_reported <= '0;
        end else if (in_accept) begin
            r_held_valid <= 1'b1;
            if (is_start) begin
                r_sample_count   <= '0;
                r_peak_seen      <= 1'b0;
                r_peaks_reported <= '0;
            end else begin
                r_sample_count <= n_sample_count;
                if (fire) begin
                    r_peak_seen      <= 1'b1;
                    r_peaks_reported <= n_peaks_reported;
                end
            end
        end
    end

    // held sample and last peak amplitude
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_held_amp <= in_amp;
            r_held_pos <= in_pos;
        end
        if (fire) begin
            r_last_peak_amp <= r_held_amp;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_index  <= r_sample_count;
            r_out_value  <= r_held_amp;
            r_out_number <= n_peaks_reported;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_number, r_out_value, r_out_index});

    // peak count and seen flag move together
    a_seen_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peak_seen == (r_peaks_reported != '0))
        else $error("peak seen flag disagrees with peak count");

    // a trace start never produces a report
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_start) |=> !$rose(r_out_valid))
        else $error("report produced on trace start");

    // a report marks the trace as having a peak
    a_fire_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_peak_seen && r_out_valid))
        else $error("report without peak state update");

    // reported peak number is never zero
    a_number_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_number != '0))
        else $error("reported peak number is zero");

    // padding width check for the packed result
    localparam int PAD_W = OUT_W - PAY_W;
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (PAD_W == 0 || (o_m_tdata >> PAY_W) == '0))
        else $error("result padding not zero");

endmodule

>>> src/frpf_eval.sv
// compare unit: flatness, region of interest and duplicate tests on the held sample
// depends on frpf_pkg

module frpf_eval
    import frpf_pkg::*;
#(
    parameter int AMP_WIDTH = AMP_WIDTH_DEF
) (
    input  logic signed [AMP_WIDTH-1:0] i_new_amp,
    input  logic signed [AMP_WIDTH-1:0] i_held_amp,
    input  logic signed [POS_WIDTH-1:0] i_held_pos,
    input  logic signed [AMP_WIDTH-1:0] i_last_amp,
    input  logic        [THR_WIDTH-1:0] i_threshold,
    input  logic        [HW_WIDTH-1:0]  i_half_width,
    output t_eval_flags                 o_flags
);

    // compare width covers both the difference magnitude and the threshold
    localparam int DW = AMP_WIDTH + 1;
    localparam int CW = (DW > THR_WIDTH) ? DW : THR_WIDTH;

    logic signed [DW-1:0] diff_step;
    logic signed [DW-1:0] diff_peak;
    logic        [DW-1:0] mag_step;
    logic        [DW-1:0] mag_peak;
    logic        [POS_WIDTH-1:0] mag_pos;
    logic        [CW-1:0] thr_ext;

    // exact differences, one bit wider than the amplitude
    assign diff_step = DW'(i_new_amp) - DW'(i_held_amp);
    assign diff_peak = DW'(i_held_amp) - DW'(i_last_amp);

    // magnitudes; the most negative value still fits unsigned
    assign mag_step = diff_step[DW-1] ? DW'(-diff_step) : DW'(diff_step);
    assign mag_peak = diff_peak[DW-1] ? DW'(-diff_peak) : DW'(diff_peak);
    assign mag_pos  = i_held_pos[POS_WIDTH-1] ? POS_WIDTH'(-i_held_pos)
                                              : POS_WIDTH'(i_held_pos);

    assign thr_ext = CW'(i_threshold);

    // decisions
    assign o_flags.flat     = CW'(mag_step) < thr_ext;
    assign o_flags.distinct = CW'(mag_peak) > thr_ext;
    assign o_flags.in_roi   = mag_pos < {1'b0, i_half_width};

endmodule

>>> bench/flat_region_peak_finder_tb.sv
// self-checking bench for flat_region_peak_finder: peak prediction, stream checks, watchdog
// depends on frpf_pkg and the flat_region_peak_finder rtl

module flat_region_peak_finder_tb
    import frpf_pkg::*;
();

    localparam int AMP_W    = AMP_WIDTH_DEF;
    localparam int IDX_W    = INDEX_WIDTH_DEF;
    localparam int IN_W     = ((POS_WIDTH + AMP_W + 7) / 8) * 8;
    localparam int OUT_W    = ((2 * IDX_W + AMP_W + 7) / 8) * 8;
    localparam longint IDX_MAX  = (64'd1 << IDX_W) - 1;
    localparam longint AMP_MIN  = -(64'sd1 <<< (AMP_W - 1));
    localparam longint AMP_MAX  = (64'sd1 <<< (AMP_W - 1)) - 1;
    localparam longint POS_MIN  = -(64'sd1 <<< (POS_WIDTH - 1));
    localparam longint POS_MAX  = (64'sd1 <<< (POS_WIDTH - 1)) - 1;
    localparam int     SETTLE   = 3;
    localparam int     STALL_LIMIT = 1000;
    localparam int     MAX_PRINTS  = 40;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic [AMP_W-1:0] value;
        logic [IDX_W-1:0] number;
    } t_peak_rec;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_W-1:0]       i_s_tdata;   // x_pos, y_amp, zero pad
    logic [0:0]            i_s_tuser;   // trace_start
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_W-1:0]      o_m_tdata;   // peak_index, peak_value, peak_number, zero pad
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [ADDR_WIDTH-1:0] i_cfg_addr;
    logic [DATA_WIDTH-1:0] i_cfg_data;

    // predictor copy of the registers and the trace history
    longint cfg_thr = longint'(THR_RESET);
    longint cfg_hw  = longint'(HW_RESET);
    longint held_amp, held_pos, last_peak_amp;
    bit     held_valid, peak_seen;
    longint sample_count, peaks_reported;

    t_peak_rec pending_peaks [$];
    int fail_count     = 0;
    int send_idle_pct  = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;

    flat_region_peak_finder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp64(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // drop all history of the current trace
    task automatic clear_history();
        held_amp       = 0;
        held_pos       = 0;
        held_valid     = 1'b0;
        sample_count   = 0;
        last_peak_amp  = 0;
        peak_seen      = 1'b0;
        peaks_reported = 0;
    endtask

    // evaluate the held sample against the new one and queue any peak it makes
    task automatic track_sample(input logic [POS_WIDTH-1:0] xr, input logic [AMP_W-1:0] yr,
                                input logic st);
        longint    x;
        longint    y;
        t_peak_rec rec;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        if (st || !held_valid) begin
            clear_history();
            held_valid = 1'b1;
        end else begin
            if (abs64(y - held_amp) < cfg_thr && abs64(held_pos) < cfg_hw) begin
                if (!peak_seen || abs64(held_amp - last_peak_amp) > cfg_thr) begin
                    if (peaks_reported < IDX_MAX)
                        peaks_reported++;
                    last_peak_amp = held_amp;
                    peak_seen     = 1'b1;
                    rec.index     = sample_count[IDX_W-1:0];
                    rec.value     = held_amp[AMP_W-1:0];
                    rec.number    = peaks_reported[IDX_W-1:0];
                    pending_peaks.push_back(rec);
                end
            end
            if (sample_count < IDX_MAX)
                sample_count++;
        end
        held_amp = y;
        held_pos = x;
    endtask

    initial clear_history();

    // follow register writes and accepted samples
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    REG_PEAK_THRESHOLD: cfg_thr = longint'(i_cfg_data[THR_WIDTH-1:0]);
                    REG_HALF_WIDTH:     cfg_hw  = longint'(i_cfg_data[HW_WIDTH-1:0]);
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready)
                track_sample(i_s_tdata[POS_WIDTH-1:0], i_s_tdata[POS_WIDTH +: AMP_W],
                             i_s_tuser[0]);
        end
    end

    // sink side: random backpressure
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // compare each accepted peak report with the oldest prediction
    always @(posedge i_clk) begin
        t_peak_rec want;
        logic [IDX_W-1:0] got_index, got_number;
        logic [AMP_W-1:0] got_value;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_index  = o_m_tdata[IDX_W-1:0];
            got_value  = o_m_tdata[IDX_W +: AMP_W];
            got_number = o_m_tdata[IDX_W + AMP_W +: IDX_W];
            if (pending_peaks.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_PRINTS)
                    $error("unexpected peak report: index %0d value %0d number %0d",
                           got_index, $signed(got_value), got_number);
            end else begin
                want = pending_peaks.pop_front();
                if (got_index !== want.index) begin
                    fail_count++;
                    if (fail_count <= MAX_PRINTS)
                        $error("peak_index: expected %0d, got %0d", want.index, got_index);
                end
                if (got_value !== want.value) begin
                    fail_count++;
                    if (fail_count <= MAX_PRINTS)
                        $error("peak_value: expected %0d, got %0d",
                               $signed(want.value), $signed(got_value));
                end
                if (got_number !== want.number) begin
                    fail_count++;
                    if (fail_count <= MAX_PRINTS)
                        $error("peak_number: expected %0d, got %0d", want.number, got_number);
                end
            end
        end
    end

    // watchdog on cycles without any request moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // send one sample, with random idle cycles ahead of it
    task automatic send_sample(input logic [POS_WIDTH-1:0] x, input logic [AMP_W-1:0] y,
                               input bit st);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        i_s_tuser  <= st;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    // stop sending and wait until every predicted peak has come out
    task automatic drain_peaks(input int settle);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_peaks.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ADDR_WIDTH-1:0] idx, input logic [DATA_WIDTH-1:0] val);
        drain_peaks(SETTLE);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random traces: plateaus and small steps with jumps, plus some raw noise
    task automatic run_traces(input int n_items);
        int     left, len, r;
        longint amp, pos, w;
        bit     st;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
            amp = longint'($signed(24'($urandom)));
            pos = longint'($urandom_range(0, int'(cfg_hw + 2)));
            if ($urandom_range(0, 1))
                pos = -pos;
            for (int k = 0; k < len && left > 0; k++) begin
                st = (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
                if ($urandom_range(0, 9) == 0)
                    send_sample($urandom, AMP_W'($urandom), st);
                else
                    send_sample(pos[POS_WIDTH-1:0], amp[AMP_W-1:0], st);
                left--;
                // next amplitude: hold, small step around the threshold, or jump
                r = $urandom_range(0, 99);
                w = cfg_thr + cfg_thr / 4 + 1;
                if (r >= 15 && r < 85)
                    amp = amp + longint'($urandom_range(0, int'(2 * w))) - w;
                else if (r >= 85)
                    amp = longint'($signed(24'($urandom)));
                amp = clamp64(amp, AMP_MIN, AMP_MAX);
                // next position: creep, or land anywhere within or just past the window
                if ($urandom_range(0, 9) == 0) begin
                    pos = longint'($urandom_range(0, int'(cfg_hw + 2)));
                    if ($urandom_range(0, 1))
                        pos = -pos;
                end else begin
                    pos = pos + longint'($urandom_range(0, 64)) - 16;
                end
                pos = clamp64(pos, POS_MIN, POS_MAX);
            end
        end
    endtask

    // boundaries of flatness, window and distinctness at the reset settings
    task automatic test_directed();
        longint t, h;
        t = longint'(THR_RESET);
        h = longint'(HW_RESET);
        send_sample(0, AMP_W'(0), 1'b0);                             // no trace started yet
        send_sample(0, AMP_W'(100), 1'b0);                           // first candidate reported
        send_sample(POS_WIDTH'(h - 1), AMP_W'(100 + t - 1), 1'b0);   // too close to last peak
        send_sample(POS_WIDTH'(h), AMP_W'(100 + t - 1), 1'b0);       // edge of window, distinct
        send_sample(POS_WIDTH'(-h), AMP_W'(100 + 2 * t - 1), 1'b0);  // step equal to threshold
        send_sample(0, AMP_W'(100 + 2 * t - 1), 1'b0);               // flat but outside window
        send_sample(0, AMP_W'(100 + 3 * t - 1), 1'b0);
        send_sample(0, AMP_W'(100 + 3 * t - 1), 1'b0);
        send_sample(0, AMP_W'(100 + 4 * t - 1), 1'b0);   // distance to last peak equals threshold
        send_sample(0, AMP_W'(100 + 4 * t), 1'b0);
        send_sample(0, AMP_W'(100 + 4 * t), 1'b0);
        send_sample(32'h7FFFFFFF, 24'h7FFFFF, 1'b0);
        send_sample(32'h80000000, 24'h7FFFFF, 1'b0);
        send_sample(32'h80000000, 24'h800000, 1'b0);
        send_sample(0, 24'h800000, 1'b0);        // most negative position never in window
        send_sample(0, 24'h800000, 1'b0);
        send_sample(5, 24'h800001, 1'b1);        // new trace drops the held sample
        send_sample(5, 24'h800000, 1'b0);
        send_sample(5, 24'h000000, 1'b1);
        send_sample(6, 24'h000000, 1'b1);        // back-to-back trace starts
        send_sample(6, 24'h000000, 1'b0);
        send_sample(7, 24'hFFFFFF, 1'b0);
        drain_peaks(SETTLE);
    endtask

    // extreme register settings, zero threshold and zero window among them
    task automatic test_register_extremes();
        write_reg(REG_PEAK_THRESHOLD, 32'd0);
        run_traces(80);
        write_reg(REG_PEAK_THRESHOLD, 32'h007FFFFF);
        write_reg(REG_HALF_WIDTH, 32'h7FFFFFFF);
        run_traces(80);
        write_reg(REG_HALF_WIDTH, 32'd0);
        run_traces(80);
        write_reg(REG_PEAK_THRESHOLD, 32'd1);
        write_reg(REG_HALF_WIDTH, 32'h7FFFFFFF);
        run_traces(80);
    endtask

    // random settings under each idling pattern, with a full pause midway
    task automatic test_idle_phases();
        int send_pcts [4] = '{0, 49, 0, 16};
        int sink_pcts [4] = '{0, 0, 49, 16};
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_PEAK_THRESHOLD, $urandom_range(2, 30000));
            write_reg(REG_HALF_WIDTH, $urandom_range(1, 32'h7FFFFFFF));
            send_idle_pct  = send_pcts[p];
            sink_stall_pct = sink_pcts[p];
            run_traces(110);
            drain_peaks(1);
            run_traces(110);
            send_idle_pct  = 0;
            sink_stall_pct = 0;
        end
    endtask

    // a steady ramp under a tight threshold and a one-unit window
    task automatic test_long_trace();
        write_reg(REG_PEAK_THRESHOLD, 32'd3);
        write_reg(REG_HALF_WIDTH, 32'd1);
        for (int k = 0; k < 80; k++)
            send_sample(0, AMP_W'(AMP_MIN + 2 * k), k == 0);
        drain_peaks(SETTLE);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_register_extremes();
        test_idle_phases();
        test_long_trace();

        drain_peaks(SETTLE);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
src/frpf_pkg.sv
src/frpf_eval.sv
src/flat_region_peak_finder.sv
bench/flat_region_peak_finder_tb.sv
